// File: src/wmul_pkg.sv
// package for the 256x256 multiplier core
// word geometry, limb types and the 32x32 split used by the cells
package wmul_pkg;
	localparam int WordW = 64;
	localparam int HalfW = 32;
	localparam int NumWords = 4;
	localparam int NumCells = 2 * NumWords;
	localparam int ColW = 2 * WordW + 4;
	localparam int CellLatency = 3;

	typedef logic [WordW-1:0] word_t;
	typedef word_t [NumWords-1:0] opnd_t;
	typedef word_t [NumCells-1:0] prod_t;
	typedef logic [ColW-1:0] col_t;
endpackage

// File: src/wmul_stream_if.sv
// valid/ready channel carrying a payload of any type
// depends on nothing
interface wmul_stream_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/wmul_pp_cell.sv
// one 64x64 partial product, four 32x32 multipliers then a registered add
// depends on wmul_pkg
module wmul_pp_cell (
	input  logic             clk,
	input  logic             en,
	input  wmul_pkg::word_t  x,
	input  wmul_pkg::word_t  y,
	output logic [2*wmul_pkg::WordW-1:0] p
);
	localparam int H = wmul_pkg::HalfW;
	logic [2*H-1:0] ll_s1, lh_s1, hl_s1, hh_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= x[H-1:0] * y[H-1:0];
			lh_s1 <= x[H-1:0] * y[2*H-1:H];
			hl_s1 <= x[2*H-1:H] * y[H-1:0];
			hh_s1 <= x[2*H-1:H] * y[2*H-1:H];
			p <= {hh_s1, ll_s1} + {{H{1'b0}}, lh_s1, {H{1'b0}}}
				+ {{H{1'b0}}, hl_s1, {H{1'b0}}};
		end
	end
endmodule

// File: src/wmul_col_cell.sv
// one column cell: sums its partial products, adds the carry handed in by its
// lower neighbour and hands the carry on; depends on wmul_pkg, wmul_pp_cell
module wmul_col_cell #(parameter int Col = 0) (
	input  logic                 clk,
	input  logic                 en,
	input  wmul_pkg::opnd_t      a,
	input  wmul_pkg::opnd_t      b,
	input  logic                 cin_valid,
	input  wmul_pkg::col_t       cin,
	output wmul_pkg::col_t       cout,
	output wmul_pkg::word_t      word
);
	localparam int W = wmul_pkg::WordW;
	localparam int N = wmul_pkg::NumWords;
	logic [2*W-1:0] pp [N];
	wmul_pkg::col_t sum_s3;
	wmul_pkg::col_t sum_d;
	wmul_pkg::col_t tot;

	for (genvar i = 0; i < N; i++) begin : g_pp
		if (Col - i >= 0 && Col - i < N) begin : g_on
			wmul_pp_cell u_pp (.clk, .en, .x(a[i]), .y(b[Col-i]), .p(pp[i]));
		end else begin : g_off
			assign pp[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) sum_s3 <= wmul_pkg::ColW'(pp[0]) + wmul_pkg::ColW'(pp[1])
			+ wmul_pkg::ColW'(pp[2]) + wmul_pkg::ColW'(pp[3]);
	end

	// column sum waits for the carry to reach this cell
	if (Col == 0) begin : g_nodly
		assign sum_d = sum_s3;
	end else begin : g_dly
		wmul_pkg::col_t dly_q [Col];
		always_ff @(posedge clk) begin
			if (en) begin
				dly_q[0] <= sum_s3;
				for (int d = 1; d < Col; d++) dly_q[d] <= dly_q[d-1];
			end
		end
		assign sum_d = dly_q[Col-1];
	end

	// carry ripples through the row one cell per register
	assign tot  = sum_d + (cin_valid ? cin : '0);
	assign cout = tot >> W;
	assign word = tot[W-1:0];
endmodule

// File: src/wide_256x256_multiplier_core.sv
// 256x256 -> 512 bit unsigned multiplier. Takes one operand pair per cycle while
// not stalled. The partial products pass the multiplier and add registers of the
// cells and the column-sum register, then the carry row, one column cell per
// register. The pipeline stalls as a whole when the output is not taken.
// Depends on wmul_pkg, wmul_stream_if, wmul_col_cell.
module wide_256x256_multiplier_core (
	input  logic clk,
	input  logic arst_n,
	wmul_stream_if.sink   a,
	wmul_stream_if.sink   b,
	wmul_stream_if.source p
);
	localparam int N = wmul_pkg::NumCells;
	localparam int L = wmul_pkg::CellLatency + N;
	logic [L-1:0] vld_q;
	logic en, in_go;
	wmul_pkg::col_t carry [N+1];
	wmul_pkg::word_t words [N];
	// carry-row staging: col k lands in stage k, later words delayed
	wmul_pkg::prod_t row_q [N];
	wmul_pkg::prod_t row_d [N];
	wmul_pkg::col_t cry_q [N];
	wmul_pkg::col_t cry_d [N];

	assign en = !vld_q[L-1] || p.ready;
	assign in_go = a.valid && b.valid && en;
	assign a.ready = en && b.valid;
	assign b.ready = en && a.valid;
	assign p.valid = vld_q[L-1];
	assign p.data = row_q[N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[L-2:0], in_go};
	end

	assign carry[0] = '0;
	for (genvar k = 0; k < N; k++) begin : g_col
		wmul_col_cell #(.Col(k)) u_col (
			.clk, .en, .a(a.data), .b(b.data),
			.cin_valid(k != 0), .cin(carry[k]),
			.cout(cry_d[k]), .word(words[k]));
		assign carry[k+1] = cry_q[k];
	end

	// stage k: add carry for column k, keep result words below k
	always_comb begin
		row_d[0] = '0;
		row_d[0][0] = words[0];
		for (int k = 1; k < N; k++) begin
			row_d[k] = row_q[k-1];
			row_d[k][k] = words[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_q <= row_d;
			cry_q <= cry_d;
		end
	end
endmodule

// File: src/wmul_checker.sv
// port-level checker for the multiplier core
// depends on wide_256x256_multiplier_core
module wmul_checker (
	input logic clk, arst_n,
	input logic a_valid, a_ready, b_valid, b_ready, p_valid, p_ready
);
	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(a_valid && a_ready) == (b_valid && b_ready)) else $error("operand skew");
	p_hold: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid && !p_ready |=> p_valid) else $error("result dropped");
	stall: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid && !p_ready |-> !a_ready) else $error("accept while stalled");
endmodule

bind wide_256x256_multiplier_core wmul_checker u_chk (
	.clk, .arst_n, .a_valid(a.valid), .a_ready(a.ready), .b_valid(b.valid),
	.b_ready(b.ready), .p_valid(p.valid), .p_ready(p.ready));
